// File: design/char_bitmap_pixel_sequencer_assert.svh
// Assertion macros shared by the character bitmap pixel sequencer modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef CHAR_BITMAP_PIXEL_SEQUENCER_ASSERT_SVH
`define CHAR_BITMAP_PIXEL_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cbps_pkg.sv
// Shared types and constants for the character bitmap pixel sequencer.
// Used by cbps_expand and char_bitmap_pixel_sequencer; no dependencies.
`timescale 1ns / 1ps

package cbps_pkg;

  localparam int unsigned PatW     = 8;
  localparam int unsigned CharW    = 12;
  localparam int unsigned ColorW   = 4;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned NumPix   = 8;
  localparam int unsigned NumPal   = 4;
  localparam int unsigned SelW     = 2;
  localparam int unsigned McFlagBit = 11;

  localparam logic [PatW-1:0]   PairHighBits = 8'hAA;
  localparam logic [PatW-1:0]   PairLowBits  = 8'h55;
  localparam logic [ColorW-1:0] Bg0Reset     = 4'd6;

  typedef enum logic [ModeW-1:0] {
    MODE_TEXT      = 3'd0,
    MODE_MC_TEXT   = 3'd1,
    MODE_BITMAP    = 3'd2,
    MODE_MC_BITMAP = 3'd3,
    MODE_ECM_TEXT  = 3'd4
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRAPHICS_MODE = 3'd0,
    REG_BG0           = 3'd1,
    REG_BG1           = 3'd2,
    REG_BG2           = 3'd3,
    REG_BG3           = 3'd4
  } cfg_reg_t;

  // Decoded cell: a four-entry palette and the selectors that index it.
  typedef struct packed {
    logic [NumPal-1:0][ColorW-1:0] pal;
    logic                          pair_mode;
    logic [PatW-1:0]               pattern;
    logic [PatW-1:0]               fg_mask;
  } dec_t;

endpackage

// File: design/cbps_expand.sv
// Final stage of the sequencer: expands a decoded cell into eight pixels.
// Depends on cbps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "char_bitmap_pixel_sequencer_assert.svh"

module cbps_expand
  import cbps_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             dec_valid,
  output logic                             dec_ready,
  input  dec_t                             dec,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [NumPix-1:0][ColorW-1:0]    pix,
  output logic [PatW-1:0]                  fg_mask
);

  logic                          out_valid_r;
  logic                          pair_r;
  logic [NumPix-1:0][ColorW-1:0] pix_r;
  logic [NumPix-1:0][ColorW-1:0] pix_nxt;
  logic [PatW-1:0]               mask_r;
  logic                          load;

  assign dec_ready = !out_valid_r || out_ready;
  assign load      = dec_valid && dec_ready;

  always_comb begin
    logic [SelW-1:0] sel;
    for (int i = 0; i < NumPix; i++) begin
      if (dec.pair_mode) begin
        sel = dec.pattern[PatW-1-2*(i>>1) -: SelW];
      end else begin
        sel = {1'b0, dec.pattern[PatW-1-i]};
      end
      pix_nxt[i] = dec.pal[sel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dec_ready) begin
      out_valid_r <= dec_valid;
    end
    if (load) begin
      pix_r  <= pix_nxt;
      mask_r <= dec.fg_mask;
      pair_r <= dec.pair_mode;
    end
  end

  assign out_valid = out_valid_r;
  assign pix       = pix_r;
  assign fg_mask   = mask_r;

  `CBPS_ASSERT_NEXT(a_out_held, out_valid_r && !out_ready, out_valid_r && $stable(pix_r), "stalled result lost")
  `CBPS_ASSERT_SAME(a_pair_pixels, out_valid_r && pair_r, pix_r[0] == pix_r[1] && pix_r[2] == pix_r[3] && pix_r[4] == pix_r[5] && pix_r[6] == pix_r[7], "pair pixels differ")
  `CBPS_ASSERT_SAME(a_black_palette, dec_valid && dec.pal == '0, pix_nxt == '0, "empty palette gave colour")

endmodule

// File: design/char_bitmap_pixel_sequencer.sv
// Top level of the character bitmap pixel sequencer: registers, decode stages.
// Depends on cbps_pkg, cbps_expand and the assertion macro header.
//
//   channel | ports                                   | direction
//   input   | in_valid/in_ready, pattern, char word    | in
//   result  | out_valid/out_ready, pixels, fg mask     | out
//   config  | cfg_we, cfg_index, cfg_wdata              | in
//
// Three register stages: input capture, palette decode and pixel expansion.
// One transfer is accepted every cycle unless a stall holds the pipeline; each item passes
// the capture, decode and expansion registers in turn before out_valid. Each stage holds its
// item while the next is full, so stalls lose nothing. Reset is synchronous; it clears the
// valid bits and returns the configuration registers to their reset values.
`timescale 1ns / 1ps
`include "char_bitmap_pixel_sequencer_assert.svh"

module char_bitmap_pixel_sequencer
  import cbps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PatW-1:0]     in_pattern_byte,
  input  logic [CharW-1:0]    in_char_word,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ColorW-1:0]   out_pixel_0,
  output logic [ColorW-1:0]   out_pixel_1,
  output logic [ColorW-1:0]   out_pixel_2,
  output logic [ColorW-1:0]   out_pixel_3,
  output logic [ColorW-1:0]   out_pixel_4,
  output logic [ColorW-1:0]   out_pixel_5,
  output logic [ColorW-1:0]   out_pixel_6,
  output logic [ColorW-1:0]   out_pixel_7,
  output logic [PatW-1:0]     out_foreground_mask
);

  logic [ModeW-1:0]              mode_r;
  logic [NumPal-1:0][ColorW-1:0] bg_r;

  logic                          s1_valid_r;
  logic [PatW-1:0]               s1_pat_r;
  logic [CharW-1:0]              s1_char_r;
  logic                          s1_ready;

  logic                          s2_valid_r;
  dec_t                          s2_dec_r;
  dec_t                          s2_dec_nxt;
  logic                          s2_ready;
  logic                          s3_ready;

  logic [NumPix-1:0][ColorW-1:0] pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeW'(MODE_TEXT);
      bg_r   <= {{ColorW{1'b0}}, {ColorW{1'b0}}, {ColorW{1'b0}}, Bg0Reset};
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRAPHICS_MODE: mode_r   <= cfg_wdata[ModeW-1:0];
        REG_BG0:           bg_r[0]  <= cfg_wdata[ColorW-1:0];
        REG_BG1:           bg_r[1]  <= cfg_wdata[ColorW-1:0];
        REG_BG2:           bg_r[2]  <= cfg_wdata[ColorW-1:0];
        REG_BG3:           bg_r[3]  <= cfg_wdata[ColorW-1:0];
        default: ;
      endcase
    end
  end

  assign s1_ready = !s1_valid_r || s2_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && s1_ready) begin
      s1_pat_r  <= in_pattern_byte;
      s1_char_r <= in_char_word;
    end
  end

  always_comb begin
    logic [ColorW-1:0] color;
    logic [ColorW-1:0] code_lo;
    logic [ColorW-1:0] code_hi;
    logic [PatW-1:0]   mc_mask;
    color   = s1_char_r[CharW-1 -: ColorW];
    code_lo = s1_char_r[ColorW-1:0];
    code_hi = s1_char_r[2*ColorW-1 -: ColorW];
    mc_mask = (s1_pat_r & PairHighBits) | ((s1_pat_r >> 1) & PairLowBits);
    s2_dec_nxt           = '0;
    s2_dec_nxt.pattern   = s1_pat_r;
    case (mode_t'(mode_r))
      MODE_TEXT: begin
        s2_dec_nxt.pal[0]  = bg_r[0];
        s2_dec_nxt.pal[1]  = color;
        s2_dec_nxt.fg_mask = s1_pat_r;
      end
      MODE_MC_TEXT: begin
        if (!s1_char_r[McFlagBit]) begin
          s2_dec_nxt.pal[0]  = bg_r[0];
          s2_dec_nxt.pal[1]  = {1'b0, color[ColorW-2:0]};
          s2_dec_nxt.fg_mask = s1_pat_r;
        end else begin
          s2_dec_nxt.pal[0]    = bg_r[0];
          s2_dec_nxt.pal[1]    = bg_r[1];
          s2_dec_nxt.pal[2]    = bg_r[2];
          s2_dec_nxt.pal[3]    = {1'b0, color[ColorW-2:0]};
          s2_dec_nxt.pair_mode = 1'b1;
          s2_dec_nxt.fg_mask   = mc_mask;
        end
      end
      MODE_BITMAP: begin
        s2_dec_nxt.pal[0]  = code_lo;
        s2_dec_nxt.pal[1]  = code_hi;
        s2_dec_nxt.fg_mask = s1_pat_r;
      end
      MODE_MC_BITMAP: begin
        s2_dec_nxt.pal[0]    = bg_r[0];
        s2_dec_nxt.pal[1]    = code_hi;
        s2_dec_nxt.pal[2]    = code_lo;
        s2_dec_nxt.pal[3]    = color;
        s2_dec_nxt.pair_mode = 1'b1;
        s2_dec_nxt.fg_mask   = mc_mask;
      end
      MODE_ECM_TEXT: begin
        s2_dec_nxt.pal[0]  = bg_r[s1_char_r[2*ColorW-1 -: SelW]];
        s2_dec_nxt.pal[1]  = color;
        s2_dec_nxt.fg_mask = s1_pat_r;
      end
      default: begin
        s2_dec_nxt.pal     = '0;
        s2_dec_nxt.fg_mask = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s1_valid_r && s2_ready) begin
      s2_dec_r <= s2_dec_nxt;
    end
  end

  cbps_expand u_expand (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (s2_valid_r),
    .dec_ready (s3_ready),
    .dec       (s2_dec_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pix       (pix),
    .fg_mask   (out_foreground_mask)
  );

  assign out_pixel_0 = pix[0];
  assign out_pixel_1 = pix[1];
  assign out_pixel_2 = pix[2];
  assign out_pixel_3 = pix[3];
  assign out_pixel_4 = pix[4];
  assign out_pixel_5 = pix[5];
  assign out_pixel_6 = pix[6];
  assign out_pixel_7 = pix[7];

  `CBPS_ASSERT_NEXT(a_s1_held, s1_valid_r && !s2_ready, s1_valid_r && $stable(s1_pat_r), "capture stage lost an item")
  `CBPS_ASSERT_NEXT(a_s2_held, s2_valid_r && !s3_ready, s2_valid_r && $stable(s2_dec_r), "decode stage lost an item")
  `CBPS_ASSERT_SAME(a_pair_mask, s2_valid_r && s2_dec_r.pair_mode, s2_dec_r.fg_mask[7] == s2_dec_r.fg_mask[6] && s2_dec_r.fg_mask[5] == s2_dec_r.fg_mask[4] && s2_dec_r.fg_mask[3] == s2_dec_r.fg_mask[2] && s2_dec_r.fg_mask[1] == s2_dec_r.fg_mask[0], "pair mask split")

endmodule

// File: verif/cbps_cell_checker.sv
// Scoreboard for the character bitmap pixel sequencer: predicts each cell and checks it.
// Depends on cbps_pkg for widths, mode codes and register indexes.
`timescale 1ns / 1ps

module cbps_cell_checker
  import cbps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [PatW-1:0]     in_pattern_byte,
  input  logic [CharW-1:0]    in_char_word,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [ColorW-1:0]   out_pixel_0,
  input  logic [ColorW-1:0]   out_pixel_1,
  input  logic [ColorW-1:0]   out_pixel_2,
  input  logic [ColorW-1:0]   out_pixel_3,
  input  logic [ColorW-1:0]   out_pixel_4,
  input  logic [ColorW-1:0]   out_pixel_5,
  input  logic [ColorW-1:0]   out_pixel_6,
  input  logic [ColorW-1:0]   out_pixel_7,
  input  logic [PatW-1:0]     out_foreground_mask,
  output int unsigned         fail_count,
  output int unsigned         cells_pending,
  output int unsigned         cells_checked
);

  typedef struct packed {
    logic [NumPix-1:0][ColorW-1:0] pix;
    logic [PatW-1:0]               mask;
  } cell_pixels_t;

  logic [ModeW-1:0]  mode_copy;
  logic [ColorW-1:0] bg_copy [NumPal];
  cell_pixels_t      expected_cells [$];
  int unsigned       errors = 0;
  int unsigned       checked = 0;

  assign fail_count    = errors;
  assign cells_checked = checked;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic cell_pixels_t render_cell(input logic [PatW-1:0] pat,
                                               input logic [CharW-1:0] cw);
    cell_pixels_t                  r;
    logic [ColorW-1:0]             fg_col;
    logic [ColorW-1:0]             bg_col;
    logic [NumPal-1:0][ColorW-1:0] pal;
    logic                          pairs;
    logic                          blank;
    logic [SelW-1:0]               sel;
    int                            hi;
    r      = '0;
    fg_col = cw[11:8];
    bg_col = bg_copy[0];
    pal    = '0;
    pairs  = 1'b0;
    blank  = 1'b0;
    case (mode_copy)
      MODE_TEXT: begin
      end
      MODE_MC_TEXT: begin
        fg_col = {1'b0, cw[10:8]};
        if (cw[McFlagBit]) begin
          pairs = 1'b1;
          pal   = {fg_col, bg_copy[2], bg_copy[1], bg_copy[0]};
        end
      end
      MODE_BITMAP: begin
        fg_col = cw[7:4];
        bg_col = cw[3:0];
      end
      MODE_MC_BITMAP: begin
        pairs = 1'b1;
        pal   = {cw[11:8], cw[3:0], cw[7:4], bg_copy[0]};
      end
      MODE_ECM_TEXT: begin
        bg_col = bg_copy[cw[7:6]];
      end
      default: begin
        blank = 1'b1;
      end
    endcase
    if (!blank) begin
      for (int i = 0; i < NumPix; i++) begin
        if (pairs) begin
          hi              = 7 - (i / 2) * 2;
          sel             = {pat[hi], pat[hi-1]};
          r.pix[i]        = pal[sel];
          r.mask[7-i]     = pat[hi];
        end else begin
          r.pix[i]        = pat[7-i] ? fg_col : bg_col;
          r.mask[7-i]     = pat[7-i];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    cell_pixels_t got_cell;
    cell_pixels_t want_cell;
    if (!rst_n) begin
      mode_copy  = MODE_TEXT;
      bg_copy[0] = Bg0Reset;
      bg_copy[1] = '0;
      bg_copy[2] = '0;
      bg_copy[3] = '0;
      expected_cells.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRAPHICS_MODE: mode_copy  = cfg_wdata[ModeW-1:0];
          REG_BG0:           bg_copy[0] = cfg_wdata;
          REG_BG1:           bg_copy[1] = cfg_wdata;
          REG_BG2:           bg_copy[2] = cfg_wdata;
          REG_BG3:           bg_copy[3] = cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready)
        expected_cells.push_back(render_cell(in_pattern_byte, in_char_word));
      if (out_valid && out_ready) begin
        got_cell.pix  = {out_pixel_7, out_pixel_6, out_pixel_5, out_pixel_4,
                         out_pixel_3, out_pixel_2, out_pixel_1, out_pixel_0};
        got_cell.mask = out_foreground_mask;
        if (expected_cells.size() == 0) begin
          report_mismatch("result transfer with no cell outstanding");
        end else begin
          want_cell = expected_cells.pop_front();
          for (int i = 0; i < NumPix; i++)
            if (got_cell.pix[i] !== want_cell.pix[i])
              report_mismatch($sformatf("cell %0d pixel_%0d: expected %0h, got %0h",
                                        checked, i, want_cell.pix[i], got_cell.pix[i]));
          if (got_cell.mask !== want_cell.mask)
            report_mismatch($sformatf("cell %0d foreground_mask: expected %02h, got %02h",
                                      checked, want_cell.mask, got_cell.mask));
        end
        checked++;
      end
    end
    cells_pending <= expected_cells.size();
  end

endmodule

// File: verif/tb_top.sv
// Top of the pixel sequencer testbench: clock, reset, register writes and cell stimulus.
// Depends on cbps_pkg, the char_bitmap_pixel_sequencer RTL and cbps_cell_checker.
`timescale 1ns / 1ps

module tb_top;
  import cbps_pkg::*;

  localparam int unsigned Latency            = 3;
  localparam int unsigned CycleLimit         = 500000;
  localparam int unsigned SettingsPerProfile = 10;
  localparam int unsigned ItemsPerSetting    = 60;
  localparam int unsigned NumModeCodes       = 1 << ModeW;
  localparam int unsigned NumRegIndexes      = 1 << CfgIdxW;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [PatW-1:0]     in_pattern_byte = '0;
  logic [CharW-1:0]    in_char_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ColorW-1:0]   out_pixel_0, out_pixel_1, out_pixel_2, out_pixel_3;
  logic [ColorW-1:0]   out_pixel_4, out_pixel_5, out_pixel_6, out_pixel_7;
  logic [PatW-1:0]     out_foreground_mask;
  int unsigned         fail_count;
  int unsigned         cells_pending;
  int unsigned         cells_checked;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         cycle_count = 0;
  int unsigned         settings_done = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  char_bitmap_pixel_sequencer dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_pattern_byte, .in_char_word,
    .out_valid, .out_ready,
    .out_pixel_0, .out_pixel_1, .out_pixel_2, .out_pixel_3,
    .out_pixel_4, .out_pixel_5, .out_pixel_6, .out_pixel_7,
    .out_foreground_mask
  );

  cbps_cell_checker checker_i (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_pattern_byte, .in_char_word,
    .out_valid, .out_ready,
    .out_pixel_0, .out_pixel_1, .out_pixel_2, .out_pixel_3,
    .out_pixel_4, .out_pixel_5, .out_pixel_6, .out_pixel_7,
    .out_foreground_mask,
    .fail_count, .cells_pending, .cells_checked
  );

  always @(posedge clk)
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d cells outstanding.",
               cycle_count, cells_pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_cell(input logic [PatW-1:0] pat, input logic [CharW-1:0] cw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_pattern_byte <= pat;
    in_char_word    <= cw;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (cells_pending != 0);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [ModeW-1:0] m,
                               input logic [ColorW-1:0] b0, input logic [ColorW-1:0] b1,
                               input logic [ColorW-1:0] b2, input logic [ColorW-1:0] b3);
    wait_idle();
    write_reg(REG_GRAPHICS_MODE, CfgDataW'(m));
    write_reg(REG_BG0, b0);
    write_reg(REG_BG1, b1);
    write_reg(REG_BG2, b2);
    write_reg(REG_BG3, b3);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_done++;
  endtask

  initial begin
    logic [ModeW-1:0]  m;
    logic [ColorW-1:0] b [NumPal];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values of the registers: standard text on background six.
    send_cell(8'h0F, 12'h3A5);

    set_registers(MODE_TEXT, 4'd1, 4'd2, 4'd3, 4'd4);
    send_cell(8'h00, 12'h000);
    send_cell(8'hFF, 12'hFFF);

    set_registers(MODE_MC_TEXT, 4'd1, 4'd2, 4'd3, 4'd4);
    send_cell(8'h1B, 12'h7C3);
    send_cell(8'h1B, 12'hF3C);
    send_cell(8'hE4, 12'hD00);

    set_registers(MODE_BITMAP, 4'd1, 4'd2, 4'd3, 4'd4);
    send_cell(8'hA5, 12'h93C);
    send_cell(8'h5A, 12'h0F0);

    set_registers(MODE_MC_BITMAP, 4'd1, 4'd2, 4'd3, 4'd4);
    send_cell(8'hE4, 12'hA5C);
    send_cell(8'h1B, 12'hFFF);

    set_registers(MODE_ECM_TEXT, 4'd1, 4'd2, 4'd3, 4'd4);
    // Writes to indexes above the last register must leave every register alone.
    for (int k = REG_BG3 + 1; k < NumRegIndexes; k++)
      write_reg(CfgIdxW'(k), 4'hF);
    cfg_we <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < NumPal; k++)
      send_cell(8'h5A, CharW'(12'hB00 | (k << 6) | 12'h015));

    for (int k = MODE_ECM_TEXT + 1; k < NumModeCodes; k++) begin
      set_registers(ModeW'(k), 4'd1, 4'd2, 4'd3, 4'd4);
      send_cell(8'hFF, 12'hFFF);
    end

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 30 : (p == 1) ? 86 : 0;
      recv_idle_pct = (p == 0) ? 86 : (p == 1) ? 30 : 0;
      for (int s = 0; s < SettingsPerProfile; s++) begin
        m = ModeW'((s + 3 * p) % NumModeCodes);
        for (int k = 0; k < NumPal; k++)
          b[k] = (s == 0) ? 4'h0 : (s == 1) ? 4'hF : ColorW'($urandom_range(0, 15));
        set_registers(m, b[0], b[1], b[2], b[3]);
        repeat (ItemsPerSetting)
          send_cell(PatW'($urandom_range(0, 255)), CharW'($urandom_range(0, 4095)));
      end
    end

    wait_idle();
    $display("Checked %0d cells over %0d register settings, all eight mode codes,",
             cells_checked, settings_done);
    $display("with sender and receiver stalls in three idling profiles.");
    if (fail_count == 0 && cells_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/cbps_pkg.sv
design/cbps_expand.sv
design/char_bitmap_pixel_sequencer.sv
verif/cbps_cell_checker.sv
verif/tb_top.sv
